// File: src/lcdfb_pkg.sv
// ----------------------------------------------------------------------------
// lcdfb_pkg
// Shared types and constants of the graphic LCD pixel store block.
// ----------------------------------------------------------------------------
package lcdfb_pkg;

  localparam int unsigned StoreColumnsDef   = 128;
  localparam int unsigned VisibleColumnsDef = 120;
  localparam logic [15:0] ReadCycleReset    = 16'd10000;

  // result queue entries, power of two
  localparam int unsigned ResultDepth = 4;

  localparam logic [7:0] CmdWritePrefix = 8'h64;
  localparam logic [7:0] CmdReadPrefix  = 8'h63;

  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_LCD    = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CYCLE  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_MODE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic serial_drive;
    logic serial_bit;
  } out_item_t;

  // one store word update: kind of operation plus its operands
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_DOT   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] column;
    logic [4:0] row;
    logic [7:0] data;
    logic       lit;
    logic       in_range;
  } work_t;

  // column offset of a controller, 40 * ((c - 1) mod 3)
  function automatic logic [7:0] ctrl_offset(input logic [2:0] c);
    logic [7:0] r;
    begin
      case (c)
        3'd1, 3'd4: r = 8'd0;
        3'd2, 3'd5: r = 8'd40;
        3'd3, 3'd6: r = 8'd80;
        default:    r = 8'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// File: src/lcdfb_front.sv
// ----------------------------------------------------------------------------
// lcdfb_front
// Decodes items, keeps the controller/cursor/serial state and issues at most one
// store operation per item.
// ----------------------------------------------------------------------------
module lcdfb_front #(
  parameter int unsigned StoreColumns   = lcdfb_pkg::StoreColumnsDef,
  parameter int unsigned VisibleColumns = lcdfb_pkg::VisibleColumnsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  lcdfb_pkg::in_item_t  item_i,
  input  logic                 mode_i,
  input  logic [15:0]          count_i,
  output lcdfb_pkg::work_t     work_o
);

  logic [2:0]  ctrl_q, ctrl_d;
  logic        cflag_q, cflag_d;
  logic        wpre_q, wpre_d;
  logic        rpre_q, rpre_d;
  logic [4:0]  crow_q, crow_d;
  logic [7:0]  ccol_q, ccol_d;
  logic [7:0]  dcol_q, dcol_d;
  logic        dval_q, dval_d;
  logic [4:0]  drow_q, drow_d;
  logic [5:0]  tick_q, tick_d;
  logic [15:0] rem_q, rem_d;

  logic [7:0]  v;
  logic        ctrl_ok;
  logic [4:0]  band;
  logic [7:0]  off;
  logic [4:0]  dstep;
  logic [6:0]  srow;
  logic        ccol_ok;
  logic        dcol_ok;

  // decode and state update
  always_comb begin
    v = item_i.value;
    ctrl_ok = (ctrl_q >= 3'd1) && (ctrl_q <= 3'd6);
    band = (ctrl_q >= 3'd4) ? 5'd16 : 5'd0;
    off = lcdfb_pkg::ctrl_offset(ctrl_q);
    dstep = '0;
    srow = 7'({2'b00, crow_q} + 7'd12 - {1'b0, tick_q});
    ccol_ok = ({24'd0, ccol_q} < 32'(VisibleColumns)) &&
              ({24'd0, ccol_q} < 32'(StoreColumns));
    dcol_ok = ({24'd0, dcol_q} < 32'(VisibleColumns)) &&
              ({24'd0, dcol_q} < 32'(StoreColumns));
    ctrl_d = ctrl_q; cflag_d = cflag_q; wpre_d = wpre_q; rpre_d = rpre_q;
    crow_d = crow_q; ccol_d = ccol_q; dcol_d = dcol_q; dval_d = dval_q;
    drow_d = drow_q; tick_d = tick_q; rem_d = rem_q;
    work_o = '0;
    work_o.op = lcdfb_pkg::OP_NONE;
    if (valid_i) begin
      case (lcdfb_pkg::cmd_e'(item_i.command))
        lcdfb_pkg::CMD_SELECT: begin
          ctrl_d = v[2:0];
          cflag_d = v[3];
        end
        lcdfb_pkg::CMD_TICK: begin
          if (tick_q != 6'd63) tick_d = tick_q + 6'd1;
        end
        lcdfb_pkg::CMD_CYCLE: begin
          if (mode_i && rem_q != 16'd0) begin
            rem_d = rem_q - 16'd1;
            if (tick_q > 6'd4) begin
              work_o.op = lcdfb_pkg::OP_READ;
              work_o.column = ccol_q;
              work_o.row = srow[4:0];
              // negative rows wrap to large values of the 7-bit difference
              work_o.in_range = (srow <= 7'd31) && ccol_ok;
            end
          end
        end
        lcdfb_pkg::CMD_LCD: begin
          if (mode_i) begin
            if (!cflag_q) begin
              work_o.op = lcdfb_pkg::OP_BYTE;
              work_o.column = ccol_q;
              work_o.row = crow_q;
              work_o.data = v;
              work_o.in_range = ccol_ok;
              if (ccol_q != 8'd255) ccol_d = ccol_q + 8'd1;
            end else if (v == lcdfb_pkg::CmdWritePrefix) begin
              wpre_d = 1'b1;
            end else if (v == lcdfb_pkg::CmdReadPrefix) begin
              rpre_d = 1'b1;
            end else if (wpre_q || rpre_q) begin
              if (ctrl_ok) begin
                if (v < 8'hC0) begin
                  crow_d = band;
                  ccol_d = v - 8'h80 + off;
                end else begin
                  crow_d = band + 5'd8;
                  ccol_d = v - 8'hC0 + off;
                end
              end
              if (wpre_q) begin
                wpre_d = 1'b0;
              end else begin
                rem_d = count_i;
                tick_d = '0;
                rpre_d = 1'b0;
              end
            end else if (dval_q) begin
              // dot row offset and pixel on or off
              if (v >= 8'h20 && v <= 8'h3C) begin
                dstep = 5'((v - 8'h20) >> 2);
                drow_d = drow_q + dstep;
                work_o.op = lcdfb_pkg::OP_DOT;
                work_o.lit = 1'b0;
              end else if (v >= 8'h40 && v <= 8'h5C) begin
                dstep = 5'((v - 8'h40) >> 2);
                drow_d = drow_q + dstep;
                work_o.op = lcdfb_pkg::OP_DOT;
                work_o.lit = 1'b1;
              end
              work_o.column = dcol_q;
              work_o.row = drow_d;
              work_o.in_range = dcol_ok;
              dval_d = 1'b0;
            end else if (ctrl_ok) begin
              if (v >= 8'h80 && v <= 8'hA7) begin
                dcol_d = v - 8'h80 + off;
                drow_d = band;
                dval_d = 1'b1;
              end else if (v >= 8'hC0 && v <= 8'hE7) begin
                dcol_d = v - 8'hC0 + off;
                drow_d = band + 5'd8;
                dval_d = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0; cflag_q <= 1'b0; wpre_q <= 1'b0; rpre_q <= 1'b0;
      crow_q <= '0; ccol_q <= '0; dcol_q <= '0; dval_q <= 1'b1;
      drow_q <= '0; tick_q <= '0; rem_q <= '0;
    end else begin
      ctrl_q <= ctrl_d; cflag_q <= cflag_d; wpre_q <= wpre_d; rpre_q <= rpre_d;
      crow_q <= crow_d; ccol_q <= ccol_d; dcol_q <= dcol_d; dval_q <= dval_d;
      drow_q <= drow_d; tick_q <= tick_d; rem_q <= rem_d;
    end
  end

`ifndef SYNTHESIS
  a_tick_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q == 6'd63 |=> tick_q == 6'd63 || tick_q == 6'd0)
    else $error("serial tick left saturation");
  a_prefix_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_o.op == lcdfb_pkg::OP_READ |-> rem_q != 16'd0)
    else $error("readback without remaining count");
  a_rem_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_o.op == lcdfb_pkg::OP_READ |=> rem_q == $past(rem_q) - 16'd1)
    else $error("remaining count not decremented");
`endif

endmodule

// File: src/lcdfb_back.sv
// ----------------------------------------------------------------------------
// lcdfb_back
// Pixel store: one column word per address, registered read at the accept
// edge, merge and write back in the following cycle with a one-deep write bypass;
// valid bit per column stands for the cleared reset content.
// ----------------------------------------------------------------------------
module lcdfb_back #(
  parameter int unsigned StoreColumns = lcdfb_pkg::StoreColumnsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  lcdfb_pkg::work_t     work_i,
  output logic                 valid_o,
  output lcdfb_pkg::out_item_t res_o
);

  localparam int unsigned AW = $clog2(StoreColumns);

  logic [31:0]             mem [StoreColumns];
  logic [StoreColumns-1:0] vld_q;
  logic [31:0]             rd_q;
  logic                    rd_vld_q;
  lcdfb_pkg::work_t        work_q;
  logic                    stage_q;
  logic [31:0]             byp_q;
  logic [AW-1:0]           byp_addr_q;
  logic                    byp_vld_q;
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic [31:0]             word;
  logic [31:0]             wdata;
  logic [31:0]             keep;
  logic                    wr_en;
  logic                    rd_op;

  assign raddr = work_i.column[AW-1:0];
  assign waddr = work_q.column[AW-1:0];

  // store read at the accept edge, write back in the following cycle
  always_ff @(posedge clk_i) begin
    rd_q <= mem[raddr];
    if (wr_en) mem[waddr] <= wdata;
  end

  // stage register, valid bits and write bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0; rd_vld_q <= 1'b0; work_q <= '0; stage_q <= 1'b0;
      byp_q <= '0; byp_addr_q <= '0; byp_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[raddr];
      work_q <= work_i;
      stage_q <= valid_i;
      byp_q <= wdata;
      byp_addr_q <= waddr;
      byp_vld_q <= wr_en;
      if (wr_en) vld_q[waddr] <= 1'b1;
    end
  end

  // merged word for byte or dot writes
  always_comb begin
    word = (byp_vld_q && byp_addr_q == waddr) ? byp_q : (rd_vld_q ? rd_q : 32'd0);
    keep = ~(32'h0000_00FF << work_q.row);
    wdata = (word & keep) | ((32'(work_q.data) << work_q.row) & ~keep);
    wr_en = 1'b0;
    case (work_q.op)
      lcdfb_pkg::OP_BYTE: wr_en = work_q.in_range;
      lcdfb_pkg::OP_DOT: begin
        wr_en = work_q.in_range;
        wdata = work_q.lit ? (word | (32'd1 << work_q.row))
                           : (word & ~(32'd1 << work_q.row));
      end
      default: ;
    endcase
  end

  // readback bit
  assign rd_op = stage_q && (work_q.op == lcdfb_pkg::OP_READ);
  assign res_o = {rd_op, rd_op && (!work_q.in_range || word[work_q.row])};
  assign valid_o = stage_q;

endmodule

// File: src/lcdfb_queue.sv
// ----------------------------------------------------------------------------
// lcdfb_queue
// Four-entry result queue between the store and the result port; full
// counts the result still in the store stage.
// ----------------------------------------------------------------------------
module lcdfb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 pend_i,
  input  lcdfb_pkg::out_item_t data_i,
  output logic                 full_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output lcdfb_pkg::out_item_t data_o
);

  localparam int unsigned AW = $clog2(lcdfb_pkg::ResultDepth);

  lcdfb_pkg::out_item_t buf_q [lcdfb_pkg::ResultDepth];
  logic [AW-1:0]        wp_q, rp_q;
  logic [AW:0]          cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (32'(cnt_q) + 32'(pend_i)) >= lcdfb_pkg::ResultDepth;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + {{(AW-1){1'b0}}, 1'b1};
      if (do_pop) rp_q <= rp_q + {{(AW-1){1'b0}}, 1'b1};
      cnt_q <= cnt_q + {{AW{1'b0}}, do_push} - {{AW{1'b0}}, do_pop};
    end
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= lcdfb_pkg::ResultDepth)
    else $error("queue count overflow");
`endif

endmodule

// File: src/lcd_controller_framebuffer_core.sv
// ----------------------------------------------------------------------------
// lcd_controller_framebuffer_core
// Graphic LCD pixel store with serial readback, queue interfaces.
// ----------------------------------------------------------------------------
// channel   ports                     width
// input     push_i/full_o, in_item_i  10 (command, value)
// result    pop_i/empty_o, out_item_o 2  (serial_drive, serial_bit)
// config    APB psel_i..prdata_o      32, two registers
//
// One item per cycle while full_o is low; the item is decoded and its column
// word read at the accept edge, merged and written back at the next edge, where
// its result enters a four-entry queue and shows on out_item_o after that edge.
// full_o rises while queued plus in-flight results reach four; with pop_i
// held high items flow back to back.
// Reset initialises all control state and marks every column as dark at once.
module lcd_controller_framebuffer_core #(
  parameter int unsigned StoreColumns   = lcdfb_pkg::StoreColumnsDef,
  parameter int unsigned VisibleColumns = lcdfb_pkg::VisibleColumnsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  lcdfb_pkg::in_item_t  in_item_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output lcdfb_pkg::out_item_t out_item_o,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [2:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  output logic [31:0]          prdata_o,
  output logic                 pready_o
);

  logic                 mode_q;
  logic [15:0]          count_q;
  logic                 acc;
  logic                 cfg_wr;
  lcdfb_pkg::work_t     work;
  lcdfb_pkg::out_item_t res;
  logic                 res_vld;
  logic                 q_full;

  assign pready_o = 1'b1;
  assign full_o = q_full;
  assign acc = push_i && !q_full;
  assign cfg_wr = psel_i && penable_i && pwrite_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      count_q <= lcdfb_pkg::ReadCycleReset;
    end else if (cfg_wr) begin
      if (paddr_i == {lcdfb_pkg::REG_MODE, 2'b00}) mode_q <= pwdata_i[0];
      if (paddr_i == {lcdfb_pkg::REG_COUNT, 2'b00}) count_q <= pwdata_i[15:0];
    end
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i == {lcdfb_pkg::REG_MODE, 2'b00}) prdata_o = {31'd0, mode_q};
    else if (paddr_i == {lcdfb_pkg::REG_COUNT, 2'b00}) prdata_o = {16'd0, count_q};
  end

  lcdfb_front #(
    .StoreColumns(StoreColumns), .VisibleColumns(VisibleColumns)
  ) u_front (
    .clk_i, .rst_ni, .valid_i(acc), .item_i(in_item_i),
    .mode_i(mode_q), .count_i(count_q), .work_o(work)
  );

  lcdfb_back #(.StoreColumns(StoreColumns)) u_back (
    .clk_i, .rst_ni, .valid_i(acc), .work_i(work),
    .valid_o(res_vld), .res_o(res)
  );

  lcdfb_queue u_queue (
    .clk_i, .rst_ni, .push_i(res_vld), .pend_i(res_vld), .data_i(res),
    .full_o(q_full), .empty_o, .pop_i, .data_o(out_item_o)
  );

`ifndef SYNTHESIS
  a_drive_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.serial_drive |-> $past(acc && in_item_i.command == lcdfb_pkg::CMD_CYCLE))
    else $error("drive on a non-cycle item");
  a_bit_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.serial_bit |-> res.serial_drive)
    else $error("serial bit without drive");
`endif

endmodule
